[rtl/core/tokt_pkg.sv]
// Shared types and constants for the timestamp-ordered keyed table.
// Used by tokt_ram's users and by the top level; depends on nothing else.
package tokt_pkg;

  localparam int TOKT_SLOTS = 16;

  // Request kinds carried in the mode field.
  typedef enum logic [1:0] {
    MODE_UPSERT = 2'd0,
    MODE_UPDATE = 2'd1,
    MODE_FIND   = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  // One table entry as stored in the entry memory.
  typedef struct packed {
    logic signed [63:0] ts;
    logic [3:0]         state;
    logic [3:0]         source;
    logic [63:0]        key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[rtl/core/tokt_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package needed.
module tokt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/timestamp_ordered_keyed_table_top.sv]
// Top level of the timestamp-ordered keyed table: request sequencer and result register.
// Depends on tokt_pkg and tokt_ram.
//
// The table keeps up to SLOTS entries in one memory, newest timestamp first. One request
// is handled at a time. A lookup reads the memory one slot at a time from the front, in
// a look step and a compare step, until the key is found or every entry has been read;
// a miss then passes through a miss step, which for upsert picks its slot. After a hit
// or an upsert miss, upsert and update move the entry toward the front one slot at a
// time, shifting each older entry back one place. Read by index reads its slot directly,
// and each request passes through an idle and a done step entering and leaving. The single
// memory read port is why slots are read one at a time. The result waits in an output
// register, so a new request is taken while the previous result is still unread.
module timestamp_ordered_keyed_table_top
  import tokt_pkg::*;
#(
  parameter int SLOTS = TOKT_SLOTS
) (
  input  logic         clk,
  input  logic         rst,
  // mode[1:0], session_key[65:2], agent_source[69:66], pet_state[73:70],
  // timestamp[137:74], read_index[141:138], zero fill [143:142]
  input  logic [143:0] s_tdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // found[0], slot_index[4:1], entry_key[68:5], entry_source[72:69],
  // entry_state[76:73], entry_time[140:77], entry_count[145:141], zero fill [151:146]
  output logic [151:0] m_tdata,
  output logic         m_tvalid,
  input  logic         m_tready
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_CMP, S_MISS, S_BRD, S_BCMP, S_RWAIT, S_DONE
  } state_t;

  state_t              state;
  mode_t               mode;
  logic [63:0]         key;
  logic [3:0]          src;
  logic [3:0]          st;
  logic signed [63:0]  ts;
  logic [3:0]          ridx;
  logic [IW-1:0]       idx;
  logic [IW-1:0]       pos;
  logic [CW-1:0]       count;
  entry_t              ent;
  logic                res_found;
  logic                res_show;
  logic [3:0]          res_idx;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  entry_t              ram_wdata;
  logic [IW-1:0]       ram_raddr;
  entry_t              ram_rdata;
  logic                newer;
  logic                rd_ok;
  logic                out_load;

  mode_t               in_mode;
  logic [3:0]          in_ridx;

  assign in_mode  = mode_t'(s_tdata[1:0]);
  assign in_ridx  = s_tdata[141:138];
  assign s_tready = (state == S_IDLE);

  // Read by index is valid only below the count and inside the table.
  assign rd_ok = ((CW + 4)'(in_ridx) < (CW + 4)'(count)) && (32'(in_ridx) < SLOTS);

  assign newer = ent.ts > ram_rdata.ts;

  // The finished result moves into the output register once that register is free.
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  // Memory read address and write port.
  always_comb begin
    unique case (state)
      S_LOOK:  ram_raddr = idx;
      S_BRD:   ram_raddr = pos - IW'(1);
      default: ram_raddr = IW'(in_ridx);
    endcase
    ram_we    = ((state == S_BRD) && (pos == '0)) || (state == S_BCMP);
    ram_waddr = pos;
    ram_wdata = ((state == S_BCMP) && newer) ? ram_rdata : ent;
  end

  tokt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Request sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            mode <= in_mode;
            key  <= s_tdata[65:2];
            src  <= s_tdata[69:66];
            st   <= s_tdata[73:70];
            ts   <= s_tdata[137:74];
            ridx <= in_ridx;
            idx  <= '0;
            if (in_mode == MODE_READ) begin
              if (rd_ok) begin
                state <= S_RWAIT;
              end else begin
                res_found <= 1'b0;
                res_show  <= 1'b0;
                res_idx   <= in_ridx;
                state     <= S_DONE;
              end
            end else if (count == '0) begin
              state <= S_MISS;
            end else begin
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (ram_rdata.key == key) begin
            pos       <= idx;
            res_found <= 1'b1;
            unique case (mode)
              MODE_UPSERT: begin
                ent   <= '{ts: ts, state: st, source: src, key: key};
                state <= S_BRD;
              end
              MODE_UPDATE: begin
                ent   <= '{ts: ts, state: st, source: ram_rdata.source, key: ram_rdata.key};
                state <= S_BRD;
              end
              default: begin
                ent      <= ram_rdata;
                res_show <= 1'b1;
                res_idx  <= 4'(idx);
                state    <= S_DONE;
              end
            endcase
          end else if (CW'(idx) + CW'(1) == count) begin
            state <= S_MISS;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_LOOK;
          end
        end
        S_MISS: begin
          res_found <= 1'b0;
          if (mode == MODE_UPSERT) begin
            ent <= '{ts: ts, state: st, source: src, key: key};
            if (count < CW'(SLOTS)) begin
              pos   <= IW'(count);
              count <= count + CW'(1);
            end else begin
              pos <= IW'(SLOTS - 1);
            end
            state <= S_BRD;
          end else begin
            res_show <= 1'b0;
            res_idx  <= '0;
            state    <= S_DONE;
          end
        end
        S_BRD: begin
          if (pos == '0) begin
            res_show <= 1'b1;
            res_idx  <= 4'(pos);
            state    <= S_DONE;
          end else begin
            state <= S_BCMP;
          end
        end
        S_BCMP: begin
          if (newer) begin
            pos   <= pos - IW'(1);
            state <= S_BRD;
          end else begin
            res_show <= 1'b1;
            res_idx  <= 4'(pos);
            state    <= S_DONE;
          end
        end
        S_RWAIT: begin
          ent       <= ram_rdata;
          res_found <= 1'b1;
          res_show  <= 1'b1;
          res_idx   <= ridx;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            m_tdata  <= {6'd0, 5'(count),
                         res_show ? ent.ts : 64'sd0,
                         res_show ? ent.state : 4'd0,
                         res_show ? ent.source : 4'd0,
                         res_show ? ent.key : 64'd0,
                         res_idx, res_found};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The count never exceeds the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(SLOTS))
    else $error("entry count above table size");

  // The count never shrinks.
  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> count >= $past(count))
    else $error("entry count decreased");

  // A shift step moves the entry one slot toward the front.
  a_shift_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_BCMP && newer) |=> pos == $past(pos) - IW'(1))
    else $error("entry did not move forward by one slot");

  // The memory is written only while a request is in progress.
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !s_tready)
    else $error("memory write while idle");

endmodule
